/* sv/fmbw_pkg.sv */
// Package for the FLAC metadata block walker.
// Holds phase codes, result kinds, the result record type and helpers; no dependencies.
package fmbw_pkg;

    localparam int OFFSET_BITS = 32;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_MAGIC = 4'd1;
    localparam logic [3:0] PH_HDR   = 4'd2;
    localparam logic [3:0] PH_PTYPE = 4'd3;
    localparam logic [3:0] PH_MLEN  = 4'd4;
    localparam logic [3:0] PH_MSKIP = 4'd5;
    localparam logic [3:0] PH_DLEN  = 4'd6;
    localparam logic [3:0] PH_DSKIP = 4'd7;
    localparam logic [3:0] PH_BLEN  = 4'd8;
    localparam logic [3:0] PH_BODY  = 4'd9;
    localparam logic [3:0] PH_DONE  = 4'd10;

    localparam logic [1:0] KIND_PICTURE = 2'd0;
    localparam logic [1:0] KIND_AUDIO   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [6:0] TYPE_PICTURE = 7'd6;
    localparam logic [31:0] MAGIC = 32'h664c6143;  // "fLaC"

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] picture_type;
        logic [31:0] mime_length;
        logic [31:0] description_length;
        logic [31:0] picture_data_offset;
        logic [31:0] picture_data_length;
        logic [31:0] audio_offset;
        logic        last;
    } t_result;

    function automatic logic [31:0] to_w32(input logic [OFFSET_BITS-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[31:0];
    endfunction

endpackage

/* sv/flac_metadata_block_walker_top.sv */
// FLAC metadata block walker top level: byte parser and a four-entry result queue.
// Depends on fmbw_pkg.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_data_byte, i_start_of_file, i_end_of_file
//  result  | out       | o_valid / i_stall  | o_result_kind .. o_audio_offset, o_last_result
//
// One byte is taken per cycle; its zero, one or two results enter the queue in that cycle.
// The rate is set by the queue: o_stall rises while fewer than two entries are free.
// Synchronous active-low reset clears phase, counters and the queue.
// A byte that follows a double-result byte may wait while the result side stalls.
module flac_metadata_block_walker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_picture_type,
    output logic [31:0] o_mime_length,
    output logic [31:0] o_description_length,
    output logic [31:0] o_picture_data_offset,
    output logic [31:0] o_picture_data_length,
    output logic [31:0] o_audio_offset,
    output logic        o_last_result
);
    import fmbw_pkg::*;

    logic [3:0]             r_ph, n_ph;
    logic [2:0]             r_bif, n_bif;
    logic [31:0]            r_ws, n_ws;
    logic [OFFSET_BITS-1:0] r_fo, n_fo;
    logic [23:0]            r_br, n_br;
    logic                   r_bl, n_bl, r_bp, n_bp;
    logic [31:0]            r_sk, n_sk;
    logic [31:0]            r_pt, n_pt, r_ml, n_ml, r_dl, n_dl, r_doff, n_doff, r_dlen, n_dlen;

    t_result    r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    t_result    res0, res1;
    logic [1:0] nres;

    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = r_cnt > 3'd2;
    assign o_valid = r_cnt != 3'd0;

    function automatic t_result mk(input logic [1:0] k, input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c, input logic [31:0] d,
                                   input logic [31:0] e, input logic [31:0] f);
        t_result r;
        r.kind = k; r.picture_type = a; r.mime_length = b; r.description_length = c;
        r.picture_data_offset = d; r.picture_data_length = e; r.audio_offset = f;
        r.last = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic [OFFSET_BITS-1:0] nxt;
        logic done;
        logic fail_now;
        logic endb;
        t_result er;
        n_ph = r_ph; n_bif = r_bif; n_ws = r_ws; n_fo = r_fo; n_br = r_br;
        n_bl = r_bl; n_bp = r_bp; n_sk = r_sk; n_pt = r_pt; n_ml = r_ml;
        n_dl = r_dl; n_doff = r_doff; n_dlen = r_dlen;
        res0 = '0; res1 = '0; nres = 2'd0;
        done = 1'b0; fail_now = 1'b0; endb = 1'b0;
        er = mk(KIND_ERROR, '0, '0, '0, '0, '0, '0);
        if (i_start_of_file) begin
            n_ph = PH_MAGIC; n_bif = '0; n_ws = '0; n_fo = '0; n_br = '0; n_bl = 1'b0;
            n_bp = 1'b0; n_sk = '0; n_pt = '0; n_ml = '0; n_dl = '0; n_doff = '0; n_dlen = '0;
        end
        nxt = n_fo + OFFSET_BITS'(1);
        case (n_ph)
            PH_MAGIC: begin
                if (i_data_byte != MAGIC[8*(3-n_bif[1:0]) +: 8]) begin
                    fail_now = 1'b1;
                end else begin
                    n_ws = {n_ws[23:0], i_data_byte};
                    n_bif = n_bif + 3'd1;
                    if (n_bif >= 3'd4) begin
                        n_bif = '0;
                        n_ph = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                if (n_bif == 3'd0) begin
                    n_bl = i_data_byte[7];
                    n_bp = i_data_byte[6:0] == TYPE_PICTURE;
                    n_ws = '0;
                    n_bif = 3'd1;
                end else begin
                    n_ws = {n_ws[23:0], i_data_byte};
                    n_bif = n_bif + 3'd1;
                    if (n_bif >= 3'd4) begin
                        n_bif = '0;
                        n_br = n_ws[23:0];
                        if (n_bp && n_br < 24'd8) begin
                            fail_now = 1'b1;
                        end else if (n_br == '0) begin
                            endb = 1'b1;
                        end else begin
                            n_ph = n_bp ? PH_PTYPE : PH_BODY;
                            n_ws = '0;
                        end
                    end
                end
            end
            PH_PTYPE, PH_MLEN, PH_MSKIP, PH_DLEN, PH_DSKIP, PH_BLEN, PH_BODY: begin
                n_br = n_br - 24'd1;
                if (n_ph inside {PH_PTYPE, PH_MLEN, PH_DLEN, PH_BLEN}) begin
                    n_ws = {n_ws[23:0], i_data_byte};
                    n_bif = n_bif + 3'd1;
                    if (n_bif >= 3'd4) begin
                        n_bif = '0;
                        done = 1'b1;
                    end
                end
                case (n_ph)
                    PH_PTYPE: if (done) begin
                        n_pt = n_ws;
                        n_ph = PH_MLEN;
                    end
                    PH_MLEN: if (done) begin
                        n_ml = n_ws;
                        if ({1'b0, n_ws} + 33'd4 > 33'(n_br)) begin
                            fail_now = 1'b1;
                        end else begin
                            n_sk = n_ws;
                            n_ph = (n_ws == '0) ? PH_DLEN : PH_MSKIP;
                        end
                    end
                    PH_MSKIP: begin
                        n_sk = n_sk - 32'd1;
                        if (n_sk == '0) n_ph = PH_DLEN;
                    end
                    PH_DLEN: if (done) begin
                        n_dl = n_ws;
                        if ({1'b0, n_ws} + 33'd20 > 33'(n_br)) begin
                            fail_now = 1'b1;
                        end else begin
                            n_sk = n_ws + 32'd16;
                            n_ph = PH_DSKIP;
                        end
                    end
                    PH_DSKIP: begin
                        n_sk = n_sk - 32'd1;
                        if (n_sk == '0) n_ph = PH_BLEN;
                    end
                    PH_BLEN: if (done) begin
                        n_dlen = n_ws;
                        n_doff = to_w32(nxt);
                        if (n_ws > 32'(n_br)) fail_now = 1'b1;
                        else n_ph = PH_BODY;
                    end
                    default: ;
                endcase
                if (!fail_now && n_br == '0) endb = 1'b1;
            end
            default: ;
        endcase
        if (fail_now) begin
            res0 = er; nres = 2'd1; n_ph = PH_DONE;
        end else if (endb) begin
            if (n_bp) begin
                res0 = mk(KIND_PICTURE, n_pt, n_ml, n_dl, n_doff, n_dlen, '0);
                nres = 2'd1;
            end
            if (n_bl) begin
                if (nres == 2'd0) res0 = mk(KIND_AUDIO, '0, '0, '0, '0, '0, to_w32(nxt));
                else res1 = mk(KIND_AUDIO, '0, '0, '0, '0, '0, to_w32(nxt));
                nres = nres + 2'd1;
                n_ph = PH_DONE;
            end else begin
                n_ph = PH_HDR;
                n_bif = '0;
            end
        end
        if (n_ph != PH_IDLE) n_fo = nxt;
        if (i_end_of_file && n_ph != PH_IDLE && n_ph != PH_DONE && nres < 2'd2) begin
            if (nres == 2'd0) res0 = er;
            else res1 = er;
            nres = nres + 2'd1;
            n_ph = PH_DONE;
        end
        if (nres == 2'd1) res0.last = 1'b1;
        if (nres == 2'd2) res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_bif <= '0; r_ws <= '0; r_fo <= '0; r_br <= '0;
            r_bl <= 1'b0; r_bp <= 1'b0; r_sk <= '0; r_pt <= '0; r_ml <= '0;
            r_dl <= '0; r_doff <= '0; r_dlen <= '0;
        end else if (in_acc) begin
            r_ph <= n_ph; r_bif <= n_bif; r_ws <= n_ws; r_fo <= n_fo; r_br <= n_br;
            r_bl <= n_bl; r_bp <= n_bp; r_sk <= n_sk; r_pt <= n_pt; r_ml <= n_ml;
            r_dl <= n_dl; r_doff <= n_doff; r_dlen <= n_dlen;
        end
    end

    // result queue: up to two pushes and one pop per cycle
    logic [1:0] push;
    assign push = in_acc ? nres : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push;
            r_rp  <= r_rp + {1'b0, out_acc};
            r_cnt <= r_cnt + {1'b0, push} - {2'b0, out_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) r_q[r_wp] <= res0;
        if (push == 2'd2) r_q[r_wp + 2'd1] <= res1;
    end

    assign o_result_kind         = r_q[r_rp].kind;
    assign o_picture_type        = r_q[r_rp].picture_type;
    assign o_mime_length         = r_q[r_rp].mime_length;
    assign o_description_length  = r_q[r_rp].description_length;
    assign o_picture_data_offset = r_q[r_rp].picture_data_offset;
    assign o_picture_data_length = r_q[r_rp].picture_data_length;
    assign o_audio_offset        = r_q[r_rp].audio_offset;
    assign o_last_result         = r_q[r_rp].last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("result queue overflow");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_ph == PH_IDLE && !i_start_of_file) |=> $stable(r_wp))
        else $error("result from byte before start");
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_ph == PH_DONE && !i_start_of_file) |-> nres == 2'd0)
        else $error("result after done");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_wp == r_rp + r_cnt[1:0])
        else $error("queue pointers out of step");

endmodule
